// ----- hw/rtl/ihce_pkg.sv -----
// ----------------------------------------------------------------------------
// ihce_pkg
// Shared types, constants and the ones-complement add for the ICMP header
// check and echo tracking core.
// ----------------------------------------------------------------------------
package ihce_pkg;

   localparam int unsigned HEADER_BYTES = 8;

   // header byte offsets
   localparam logic [15:0] OFF_TYPE     = 16'd0;
   localparam logic [15:0] OFF_CODE     = 16'd1;
   localparam logic [15:0] OFF_IDENT_HI = 16'd4;
   localparam logic [15:0] OFF_IDENT_LO = 16'd5;
   localparam logic [15:0] OFF_SEQ_HI   = 16'd6;
   localparam logic [15:0] OFF_SEQ_LO   = 16'd7;

   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
   localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

   // ICMP types
   localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
   localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;

   // result word layout, lowest bit up
   localparam int unsigned RSP_TYPE_LSB    = 0;
   localparam int unsigned RSP_CODE_LSB    = 8;
   localparam int unsigned RSP_IDENT_LSB   = 16;
   localparam int unsigned RSP_SEQ_LSB     = 32;
   localparam int unsigned RSP_BAD_BIT     = 48;
   localparam int unsigned RSP_SHORT_BIT   = 49;
   localparam int unsigned RSP_ECHO_BIT    = 50;
   localparam int unsigned RSP_PEND_BIT    = 51;
   localparam int unsigned RSP_SAVED_LSB   = 52;
   localparam int unsigned RSP_USED_BITS   = 68;
   localparam int unsigned RSP_TDATA_W     = 72;

   // one finished message, front to back
   typedef struct packed {
      logic [7:0]  msg_type;
      logic [7:0]  msg_code;
      logic [15:0] ident;
      logic [15:0] seq_number;
      logic        sum_ok;
      logic        too_short;
   } summary_type;

   // one result word
   typedef struct packed {
      logic [7:0]  msg_type;
      logic [7:0]  msg_code;
      logic [15:0] ident;
      logic [15:0] seq_number;
      logic        checksum_bad;
      logic        too_short;
      logic        is_echo;
      logic        echo_pending_out;
      logic [15:0] saved_seq_out;
   } result_type;

   // 16-bit ones-complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// ----- hw/rtl/icmp_header_check_echo_track_core.sv -----
// ----------------------------------------------------------------------------
// icmp_header_check_echo_track_core
// ICMP message checker: header capture, ones-complement checksum test and
// echo request/reply tracking, one message byte per word.
// ----------------------------------------------------------------------------
//
//  channel | dir | per word                      | when
//  --------+-----+-------------------------------+-----------------------------
//  req_*   | in  | one message byte, tlast=final | any byte of a message
//  rsp_*   | out | one message report            | once per message, after tlast
//
//  Takes one byte per cycle while req_tready is high; after the final byte is
//  accepted, its summary is registered in the queue, then in the output register.
//  Per byte: one 16-bit end-around-carry add, a byte count step and header capture.
//  Reset clears byte count, checksum, captured header and echo tracking state.
//  Stalls on rsp_* fill the output register, then the summary queue
//  (QUEUE_DEPTH messages); req_tready drops only when that queue is full.
//
module icmp_header_check_echo_track_core #(
   parameter int unsigned QUEUE_DEPTH = 2   // messages between intake and output, 2 or more
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] msg_type, [15:8] msg_code, [31:16] ident, [47:32] seq_number,
   // [48] checksum_bad, [49] too_short, [50] is_echo, [51] echo_pending_out,
   // [67:52] saved_seq_out, [71:68] zero
   output logic [ihce_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import ihce_pkg::*;

   logic        q_full;
   logic        q_push;
   summary_type q_push_data;
   logic        q_pop;
   logic        q_not_empty;
   summary_type q_head;
   result_type  result;

   // intake: count bytes, capture header fields, run the checksum
   ihce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // hold finished message summaries so intake keeps going during output stalls
   ihce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // result side: apply echo tracking in message order and register the report
   ihce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (result)
   );

   // pack the report, lowest field first; pad the top nibble with zero
   assign rsp_tdata = {
      4'd0,
      result.saved_seq_out,
      result.echo_pending_out,
      result.is_echo,
      result.too_short,
      result.checksum_bad,
      result.seq_number,
      result.ident,
      result.msg_code,
      result.msg_type
   };

endmodule

// ----- hw/rtl/ihce_front.sv -----
// ----------------------------------------------------------------------------
// ihce_front
// Byte intake: header capture, byte count and running checksum; pushes one
// summary per message into the queue on the last byte.
// ----------------------------------------------------------------------------
module ihce_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  logic                 q_full,
   output logic                 q_push,
   output ihce_pkg::summary_type q_push_data
);
   import ihce_pkg::*;

   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  odd_ff, odd_in;
   logic        pair_ff, pair_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] seq_ff, seq_in;

   logic        take;
   logic [15:0] add_word;
   logic [15:0] sum_add;
   logic [15:0] count_after;
   logic [7:0]  type_cap, code_cap;
   logic [15:0] ident_cap, seq_cap;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   // closing a pair adds {held, byte}; a lone final byte is padded with zero
   assign add_word    = pair_ff ? {odd_ff, data_byte} : {data_byte, 8'h00};
   assign sum_add     = oc_add(sum_ff, add_word);
   assign count_after = (byte_count_ff == COUNT_MAX) ? COUNT_MAX : byte_count_ff + 16'd1;

   always_comb begin
      type_cap  = type_ff;
      code_cap  = code_ff;
      ident_cap = ident_ff;
      seq_cap   = seq_ff;
      case (byte_count_ff)
         OFF_TYPE:     type_cap         = data_byte;
         OFF_CODE:     code_cap         = data_byte;
         OFF_IDENT_HI: ident_cap[15:8]  = data_byte;
         OFF_IDENT_LO: ident_cap[7:0]   = data_byte;
         OFF_SEQ_HI:   seq_cap[15:8]    = data_byte;
         OFF_SEQ_LO:   seq_cap[7:0]     = data_byte;
         default: ;
      endcase
   end

   assign q_push                  = take && last_byte;
   assign q_push_data.msg_type    = type_cap;
   assign q_push_data.msg_code    = code_cap;
   assign q_push_data.ident       = ident_cap;
   assign q_push_data.seq_number  = seq_cap;
   assign q_push_data.sum_ok      = (sum_add == SUM_GOOD);
   assign q_push_data.too_short   = (count_after < 16'(HEADER_BYTES));

   always_comb begin
      byte_count_in = byte_count_ff;
      sum_in        = sum_ff;
      odd_in        = odd_ff;
      pair_in       = pair_ff;
      type_in       = type_ff;
      code_in       = code_ff;
      ident_in      = ident_ff;
      seq_in        = seq_ff;
      if (take) begin
         if (last_byte) begin
            // message done: clear per-message state
            byte_count_in = '0;
            sum_in        = '0;
            odd_in        = '0;
            pair_in       = 1'b0;
            type_in       = '0;
            code_in       = '0;
            ident_in      = '0;
            seq_in        = '0;
         end else begin
            byte_count_in = count_after;
            type_in       = type_cap;
            code_in       = code_cap;
            ident_in      = ident_cap;
            seq_in        = seq_cap;
            if (pair_ff) begin
               sum_in  = sum_add;
               odd_in  = '0;
               pair_in = 1'b0;
            end else begin
               odd_in  = data_byte;
               pair_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         sum_ff        <= '0;
         odd_ff        <= '0;
         pair_ff       <= 1'b0;
         type_ff       <= '0;
         code_ff       <= '0;
         ident_ff      <= '0;
         seq_ff        <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         sum_ff        <= sum_in;
         odd_ff        <= odd_in;
         pair_ff       <= pair_in;
         type_ff       <= type_in;
         code_ff       <= code_in;
         ident_ff      <= ident_in;
         seq_ff        <= seq_in;
      end
   end

endmodule

// ----- hw/rtl/ihce_queue.sv -----
// ----------------------------------------------------------------------------
// ihce_queue
// Small FIFO of message summaries between intake and result side.
// ----------------------------------------------------------------------------
module ihce_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ihce_pkg::summary_type push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output ihce_pkg::summary_type head
);
   import ihce_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   summary_type       entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/ihce_back.sv -----
// ----------------------------------------------------------------------------
// ihce_back
// Result side: echo tracking state and the registered result word.
// ----------------------------------------------------------------------------
module ihce_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  ihce_pkg::summary_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ihce_pkg::result_type  rsp_result
);
   import ihce_pkg::*;

   logic        out_valid_ff, out_valid_in;
   result_type  result_ff, result_in;
   logic        pend_ff, pend_in;
   logic [15:0] saved_ff, saved_in;
   logic        is_request, is_reply, echo;

   assign q_pop      = q_not_empty && (!out_valid_ff || rsp_ready);
   assign is_request = (q_head.msg_type == TYPE_ECHO_REQUEST);
   assign is_reply   = (q_head.msg_type == TYPE_ECHO_REPLY);
   assign echo       = !q_head.too_short && (is_request || is_reply);

   always_comb begin
      pend_in      = pend_ff;
      saved_in     = saved_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      result_in    = result_ff;
      if (q_pop) begin
         if (echo) begin
            pend_in = is_request;
         end
         if (echo && is_request) begin
            saved_in = q_head.seq_number;
         end
         out_valid_in                = 1'b1;
         result_in.msg_type          = q_head.msg_type;
         result_in.msg_code          = q_head.msg_code;
         result_in.ident             = q_head.ident;
         result_in.seq_number        = q_head.seq_number;
         result_in.checksum_bad      = q_head.too_short || !q_head.sum_ok;
         result_in.too_short         = q_head.too_short;
         result_in.is_echo           = echo;
         result_in.echo_pending_out  = pend_in;
         result_in.saved_seq_out     = saved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         saved_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         saved_ff     <= saved_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;

endmodule

// ----- hw/rtl/ihce_checker.sv -----
// ----------------------------------------------------------------------------
// ihce_checker
// Port-level checks on the report stream of the ICMP checker core.
// ----------------------------------------------------------------------------
module ihce_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [7:0]                       req_tdata,
   input logic                             req_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ihce_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ihce_pkg::*;

   logic [7:0]  r_type;
   logic [15:0] r_seq;
   logic [15:0] r_saved;
   logic        r_bad, r_short, r_echo, r_pend;
   logic        unused_req;

   assign r_type     = rsp_tdata[RSP_TYPE_LSB +: 8];
   assign r_seq      = rsp_tdata[RSP_SEQ_LSB +: 16];
   assign r_saved    = rsp_tdata[RSP_SAVED_LSB +: 16];
   assign r_bad      = rsp_tdata[RSP_BAD_BIT];
   assign r_short    = rsp_tdata[RSP_SHORT_BIT];
   assign r_echo     = rsp_tdata[RSP_ECHO_BIT];
   assign r_pend     = rsp_tdata[RSP_PEND_BIT];
   assign unused_req = req_tvalid ^ req_tready ^ req_tlast ^ (^req_tdata);

   // stalled report holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("report changed while stalled");

   // a short message always fails the checksum and is never an echo
   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r_short |-> r_bad && !r_echo)
      else $error("short message report inconsistent");

   // an echo reply leaves nothing pending
   a_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r_echo && (r_type == TYPE_ECHO_REPLY) |-> !r_pend)
      else $error("echo reply left request pending");

   // an echo request is pending and its sequence number saved
   a_request: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r_echo && (r_type == TYPE_ECHO_REQUEST) |-> r_pend && (r_saved == r_seq))
      else $error("echo request not tracked");

   // only echo types may be flagged as echo
   a_echo_type: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r_echo |-> (r_type == TYPE_ECHO_REPLY) || (r_type == TYPE_ECHO_REQUEST)
                               || unused_req && !unused_req)
      else $error("non-echo type flagged as echo");

endmodule

bind icmp_header_check_echo_track_core ihce_checker u_ihce_checker (.*);

// ----- tb/tb_icmp_header_check_echo_track_core.sv -----
// ----------------------------------------------------------------------------
// tb_icmp_header_check_echo_track_core
// Self-checking bench for the ICMP header check and echo tracking core.
// Feeds ICMP messages byte by byte, predicts each message report in a small
// scoreboard and compares every report field by field. Runs directed corner
// messages first (short, odd, echo, all ones and all zeros), then random
// traffic under changing flow control, including a long output stall.
// ----------------------------------------------------------------------------
module tb_icmp_header_check_echo_track_core;
   import ihce_pkg::*;

   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned PHASE_BYTES  = 500;

   // tracks message state and holds the reports still to come
   class icmp_report_board;
      logic [15:0] byte_count;
      logic [15:0] sum_accum;
      logic [7:0]  held_byte;
      bit          pair_open;
      logic [7:0]  type_reg;
      logic [7:0]  code_reg;
      logic [15:0] ident_reg;
      logic [15:0] seq_reg;
      bit          echo_pending;
      logic [15:0] saved_seq;
      result_type  report_q[$];
      int unsigned mismatches;

      function new();
         echo_pending = 1'b0;
         saved_seq    = '0;
         mismatches   = 0;
         clear_message();
      endfunction

      function void clear_message();
         byte_count = '0;
         sum_accum  = '0;
         held_byte  = '0;
         pair_open  = 1'b0;
         type_reg   = '0;
         code_reg   = '0;
         ident_reg  = '0;
         seq_reg    = '0;
      endfunction

      function logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
         logic [31:0] s;
         s = 32'(a) + 32'(b);
         s = (s & 32'h0000_FFFF) + (s >> 16);
         return s[15:0];
      endfunction

      function int unsigned outstanding();
         return report_q.size();
      endfunction

      // advance the prediction by one accepted byte
      function void note_byte(input logic [7:0] b, input logic last);
         result_type r;
         bit         short_msg;
         case (byte_count)
            OFF_TYPE:     type_reg        = b;
            OFF_CODE:     code_reg        = b;
            OFF_IDENT_HI: ident_reg[15:8] = b;
            OFF_IDENT_LO: ident_reg[7:0]  = b;
            OFF_SEQ_HI:   seq_reg[15:8]   = b;
            OFF_SEQ_LO:   seq_reg[7:0]    = b;
            default: ;
         endcase
         if (pair_open) begin
            sum_accum = fold_add(sum_accum, {held_byte, b});
            pair_open = 1'b0;
            held_byte = '0;
         end else begin
            held_byte = b;
            pair_open = 1'b1;
         end
         if (byte_count != COUNT_MAX)
            byte_count++;
         if (!last)
            return;
         // pad an odd final byte with a zero low byte
         if (pair_open)
            sum_accum = fold_add(sum_accum, {held_byte, 8'h00});
         short_msg = (byte_count < HEADER_BYTES);
         r.is_echo = 1'b0;
         if (!short_msg) begin
            if (type_reg == TYPE_ECHO_REPLY) begin
               echo_pending = 1'b0;
               r.is_echo    = 1'b1;
            end else if (type_reg == TYPE_ECHO_REQUEST) begin
               echo_pending = 1'b1;
               saved_seq    = seq_reg;
               r.is_echo    = 1'b1;
            end
         end
         r.msg_type         = type_reg;
         r.msg_code         = code_reg;
         r.ident            = ident_reg;
         r.seq_number       = seq_reg;
         r.checksum_bad     = short_msg || (sum_accum != SUM_GOOD);
         r.too_short        = short_msg;
         r.echo_pending_out = echo_pending;
         r.saved_seq_out    = saved_seq;
         report_q.push_back(r);
         clear_message();
      endfunction

      // compare one accepted report word with the oldest prediction
      function void check_report(input logic [RSP_TDATA_W-1:0] word);
         result_type want;
         result_type got;
         got.msg_type         = word[RSP_TYPE_LSB +: 8];
         got.msg_code         = word[RSP_CODE_LSB +: 8];
         got.ident            = word[RSP_IDENT_LSB +: 16];
         got.seq_number       = word[RSP_SEQ_LSB +: 16];
         got.checksum_bad     = word[RSP_BAD_BIT];
         got.too_short        = word[RSP_SHORT_BIT];
         got.is_echo          = word[RSP_ECHO_BIT];
         got.echo_pending_out = word[RSP_PEND_BIT];
         got.saved_seq_out    = word[RSP_SAVED_LSB +: 16];
         if (report_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected report word %h", word);
            return;
         end
         want = report_q.pop_front();
         if (got.msg_type !== want.msg_type || got.msg_code !== want.msg_code ||
             got.ident !== want.ident || got.seq_number !== want.seq_number ||
             got.checksum_bad !== want.checksum_bad || got.too_short !== want.too_short ||
             got.is_echo !== want.is_echo ||
             got.echo_pending_out !== want.echo_pending_out ||
             got.saved_seq_out !== want.saved_seq_out) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("report mismatch at %0t", $realtime);
               $write("  want type %h code %h ident %h seq %h",
                      want.msg_type, want.msg_code, want.ident, want.seq_number);
               $display(" bad %b short %b echo %b pend %b saved %h",
                        want.checksum_bad, want.too_short, want.is_echo,
                        want.echo_pending_out, want.saved_seq_out);
               $write("  got  type %h code %h ident %h seq %h",
                      got.msg_type, got.msg_code, got.ident, got.seq_number);
               $display(" bad %b short %b echo %b pend %b saved %h",
                        got.checksum_bad, got.too_short, got.is_echo,
                        got.echo_pending_out, got.saved_seq_out);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;   // [7:0] data_byte
   logic                   req_tlast = 1'b0; // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // report fields, msg_type in the lowest bits

   icmp_report_board board;
   logic [7:0]       msg_buf[$];
   int unsigned      bytes_sent = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;
   int unsigned      hold_cycles = 0;
   int unsigned      stall_cycles;
   int unsigned      goal;

   icmp_header_check_echo_track_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // offer one byte, idling first at the current rate, hold until taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic play_msg();
      foreach (msg_buf[i])
         send_byte(msg_buf[i], i == msg_buf.size() - 1);
   endtask

   // fill msg_buf with random bytes; seal writes a checksum that verifies (length 4 or more)
   task automatic build_msg(input int unsigned len, input logic [7:0] kind, input bit seal);
      logic [15:0] sum;
      logic [16:0] s;
      logic [15:0] pair;
      msg_buf.delete();
      repeat (len)
         msg_buf.push_back(8'($urandom_range(255)));
      msg_buf[0] = kind;
      if (seal && len >= 4) begin
         msg_buf[2] = 8'h00;
         msg_buf[3] = 8'h00;
         sum = '0;
         for (int i = 0; i < len; i += 2) begin
            pair = {msg_buf[i], (i + 1 < len) ? msg_buf[i + 1] : 8'h00};
            s    = {1'b0, sum} + {1'b0, pair};
            sum  = s[15:0] + {15'd0, s[16]};
         end
         {msg_buf[2], msg_buf[3]} = ~sum;
      end
   endtask

   task automatic random_msg();
      int unsigned len;
      int unsigned pick;
      logic [7:0]  kind;
      pick = $urandom_range(99);
      if (pick < 12)
         len = $urandom_range(1, 7);
      else if (pick < 90)
         len = $urandom_range(8, 24);
      else
         len = $urandom_range(25, 64);
      pick = $urandom_range(99);
      if (pick < 35)
         kind = TYPE_ECHO_REQUEST;
      else if (pick < 65)
         kind = TYPE_ECHO_REPLY;
      else
         kind = 8'($urandom_range(255));
      build_msg(len, kind, $urandom_range(99) < 75);
      play_msg();
   endtask

   // pause the sender until every predicted report is back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // receiver: long hold-off when asked, random back-pressure otherwise
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_byte(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_report(rsp_tdata);
   end

   // end the run when nothing moves for too long
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      board = new();
      send_idle_pct = 26;
      recv_idle_pct = 56;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // short messages: one byte, then seven with an echo request type
      build_msg(1, TYPE_ECHO_REQUEST, 1'b0);
      play_msg();
      build_msg(7, TYPE_ECHO_REQUEST, 1'b1);
      play_msg();
      // well-formed echo request, then its reply
      build_msg(8, TYPE_ECHO_REQUEST, 1'b1);
      play_msg();
      build_msg(8, TYPE_ECHO_REPLY, 1'b1);
      play_msg();
      // echo request with a broken checksum
      build_msg(8, TYPE_ECHO_REQUEST, 1'b1);
      msg_buf[7] = msg_buf[7] ^ 8'h01;
      play_msg();
      // odd length, non-echo type
      build_msg(9, 8'd3, 1'b1);
      play_msg();
      // all ones and all zeros
      build_msg(8, 8'hFF, 1'b0);
      foreach (msg_buf[i]) msg_buf[i] = 8'hFF;
      play_msg();
      build_msg(8, TYPE_ECHO_REPLY, 1'b0);
      foreach (msg_buf[i]) msg_buf[i] = 8'h00;
      play_msg();
      build_msg(20, TYPE_ECHO_REQUEST, 1'b1);
      play_msg();
      build_msg(21, TYPE_ECHO_REPLY, 1'b1);
      play_msg();
      build_msg(2, 8'h00, 1'b0);
      play_msg();
      wait_drain();

      // random traffic, sender lightly idle, receiver heavily
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal)
         random_msg();
      wait_drain();

      // swap idle rates; stall the output while short messages pile up
      send_idle_pct = 56;
      recv_idle_pct = 26;
      hold_cycles = 300;
      repeat (12) begin
         build_msg($urandom_range(1, 3), 8'($urandom_range(255)), 1'b0);
         play_msg();
      end
      wait_drain();
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal)
         random_msg();
      wait_drain();

      // full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal)
         random_msg();
      wait_drain();

      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
